// ----- rtl/core/ctau_pkg.sv -----
package ctau_pkg;

  localparam int MAX_TRACKS = 32;
  localparam int COORD_BITS = 12;
  localparam int TOL_W      = 12;
  localparam int ID_W       = 32;
  localparam int EV_W       = 3;
  localparam int OP_W       = 2;

  localparam int IDX_W  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int D2_W   = SQ_W + 1;
  localparam int TOL2_W = 2 * TOL_W;
  localparam int CMP_W  = (D2_W > TOL2_W) ? D2_W : TOL2_W;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(20);

  localparam int IN_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ID_W + 2 * COORD_BITS + 7) / 8) * 8;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [ID_W-1:0]       id_t;
  typedef logic [TOL2_W-1:0]     tol2_t;

  typedef enum logic [OP_W-1:0] {
    OP_FRAME_START = 2'd0,
    OP_DETECT      = 2'd1,
    OP_FRAME_END   = 2'd2
  } op_e;

  typedef enum logic [EV_W-1:0] {
    EV_FRAME_START = 3'd0,
    EV_MOVED       = 3'd1,
    EV_RECOGNISED  = 3'd2,
    EV_LOST        = 3'd3,
    EV_FRAME_END   = 3'd4,
    EV_TABLE_FULL  = 3'd5
  } event_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FS,
    S_DET_SCAN,
    S_DET_DRAIN,
    S_DET_RD,
    S_DET_EMIT,
    S_FE_CHK,
    S_FE_EMIT,
    S_FE_END
  } ctrl_state_e;

  // One table entry as it sits in the track memory.
  typedef struct packed {
    id_t    ident;
    coord_t y;
    coord_t x;
  } track_word_t;

  // Slot read issued to the distance unit.
  typedef struct packed {
    logic valid;
    logic slot_valid;
    idx_t idx;
  } issue_t;

  typedef struct packed {
    logic valid;
    logic hit;
    idx_t idx;
  } dist_res_t;

  typedef struct packed {
    logic   valid;
    event_e ev;
    id_t    ident;
    coord_t x;
    coord_t y;
    logic   last;
  } result_t;

endpackage

// ----- rtl/core/ctau_track_mem.sv -----
module ctau_track_mem
  import ctau_pkg::*;
(
  input  logic        clk_i,
  input  logic        we_i,
  input  idx_t        waddr_i,
  input  track_word_t wdata_i,
  input  idx_t        raddr_i,
  output track_word_t rdata_o
);

  track_word_t mem_q [MAX_TRACKS];
  track_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/ctau_dist_unit.sv -----
module ctau_dist_unit
  import ctau_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  idx_t      in_idx_i,
  input  coord_t    trk_x_i,
  input  coord_t    trk_y_i,
  input  coord_t    det_x_i,
  input  coord_t    det_y_i,
  input  tol2_t     tol2_i,
  output dist_res_t res_o,
  output logic      busy_o
);

  // Stage 1: absolute differences.
  logic   s1_valid_q;
  idx_t   s1_idx_q;
  coord_t s1_dx_q, s1_dy_q;
  // Stage 2: squares.
  logic   s2_valid_q;
  idx_t   s2_idx_q;
  logic [SQ_W-1:0] s2_sqx_q, s2_sqy_q;
  // Stage 3: compare result.
  logic   s3_valid_q, s3_hit_q;
  idx_t   s3_idx_q;

  coord_t          dx_d, dy_d;
  logic [D2_W-1:0] d2;

  always_comb begin
    dx_d = (trk_x_i >= det_x_i) ? (trk_x_i - det_x_i) : (det_x_i - trk_x_i);
    dy_d = (trk_y_i >= det_y_i) ? (trk_y_i - det_y_i) : (det_y_i - trk_y_i);
    d2   = D2_W'(s2_sqx_q) + D2_W'(s2_sqy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= in_idx_i;
    s1_dx_q  <= dx_d;
    s1_dy_q  <= dy_d;
    s2_idx_q <= s1_idx_q;
    s2_sqx_q <= SQ_W'(s1_dx_q) * SQ_W'(s1_dx_q);
    s2_sqy_q <= SQ_W'(s1_dy_q) * SQ_W'(s1_dy_q);
    s3_idx_q <= s2_idx_q;
    s3_hit_q <= CMP_W'(d2) < CMP_W'(tol2_i);
  end

  assign res_o.valid = s3_valid_q;
  assign res_o.hit   = s3_hit_q;
  assign res_o.idx   = s3_idx_q;
  assign busy_o      = s1_valid_q | s2_valid_q | s3_valid_q;

endmodule

// ----- rtl/core/ctau_ctrl.sv -----
module ctau_ctrl
  import ctau_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [OP_W-1:0] op_i,
  input  coord_t      pos_x_i,
  input  coord_t      pos_y_i,
  input  logic        out_free_i,
  output result_t     result_o,
  output idx_t        mem_raddr_o,
  input  track_word_t mem_rdata_i,
  output logic        mem_we_o,
  output idx_t        mem_waddr_o,
  output track_word_t mem_wdata_o,
  output issue_t      issue_o,
  output coord_t      det_x_o,
  output coord_t      det_y_o,
  input  dist_res_t   dist_res_i,
  input  logic        dist_busy_i
);

  localparam idx_t LAST_IDX = IDX_W'(MAX_TRACKS - 1);

  ctrl_state_e state_q, state_d;
  idx_t   scan_q, scan_d, sel_q, sel_d;
  idx_t   hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic   hit_found_q, hit_found_d, free_found_q, free_found_d;
  coord_t px_q, px_d, py_q, py_d;
  issue_t iss_q, iss_d;
  id_t    id_cnt_q, id_cnt_d, id_next;
  logic [MAX_TRACKS-1:0] slot_valid_q, slot_valid_d, slot_seen_q, slot_seen_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      iss_q        <= '0;
      id_cnt_q     <= '0;
      slot_valid_q <= '0;
      slot_seen_q  <= '0;
    end else begin
      state_q      <= state_d;
      hit_found_q  <= hit_found_d;
      free_found_q <= free_found_d;
      iss_q        <= iss_d;
      id_cnt_q     <= id_cnt_d;
      slot_valid_q <= slot_valid_d;
      slot_seen_q  <= slot_seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    sel_q      <= sel_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    px_q       <= px_d;
    py_q       <= py_d;
  end

  assign id_next = id_cnt_q + ID_W'(1);

  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    sel_d        = sel_q;
    hit_idx_d    = hit_idx_q;
    hit_found_d  = hit_found_q;
    free_idx_d   = free_idx_q;
    free_found_d = free_found_q;
    px_d         = px_q;
    py_d         = py_q;
    id_cnt_d     = id_cnt_q;
    slot_valid_d = slot_valid_q;
    slot_seen_d  = slot_seen_q;
    iss_d        = '0;
    in_ready_o   = 1'b0;
    result_o     = '0;
    mem_we_o     = 1'b0;
    mem_waddr_o  = sel_q;
    mem_wdata_o  = '0;
    mem_raddr_o  = (state_q == S_DET_SCAN) ? scan_q : sel_q;

    // Record the first slot that matches, in slot order.
    if (dist_res_i.valid && dist_res_i.hit && !hit_found_q) begin
      hit_found_d = 1'b1;
      hit_idx_d   = dist_res_i.idx;
    end

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (op_i)
            OP_FRAME_START: state_d = S_FS;
            OP_DETECT: begin
              px_d         = pos_x_i;
              py_d         = pos_y_i;
              scan_d       = '0;
              hit_found_d  = 1'b0;
              free_found_d = 1'b0;
              state_d      = S_DET_SCAN;
            end
            OP_FRAME_END: begin
              sel_d   = LAST_IDX;
              state_d = S_FE_CHK;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_FS: begin
        if (out_free_i) begin
          result_o.valid = 1'b1;
          result_o.ev    = EV_FRAME_START;
          result_o.last  = 1'b1;
          slot_seen_d    = '0;
          state_d        = S_IDLE;
        end
      end
      S_DET_SCAN: begin
        iss_d.valid      = 1'b1;
        iss_d.slot_valid = slot_valid_q[scan_q];
        iss_d.idx        = scan_q;
        if (!slot_valid_q[scan_q] && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = scan_q;
        end
        if (scan_q == LAST_IDX) begin
          state_d = S_DET_DRAIN;
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end
      S_DET_DRAIN: begin
        if (!iss_q.valid && !dist_busy_i) begin
          sel_d   = hit_found_q ? hit_idx_q : free_idx_q;
          state_d = S_DET_RD;
        end
      end
      S_DET_RD: state_d = S_DET_EMIT;
      S_DET_EMIT: begin
        if (out_free_i) begin
          result_o.valid = 1'b1;
          result_o.last  = 1'b1;
          result_o.x     = px_q;
          result_o.y     = py_q;
          if (hit_found_q) begin
            result_o.ev          = EV_MOVED;
            result_o.ident       = mem_rdata_i.ident;
            mem_we_o             = 1'b1;
            mem_wdata_o          = '{ident: mem_rdata_i.ident, y: py_q, x: px_q};
            slot_seen_d[sel_q]   = 1'b1;
          end else if (free_found_q) begin
            result_o.ev          = EV_RECOGNISED;
            result_o.ident       = id_next;
            mem_we_o             = 1'b1;
            mem_wdata_o          = '{ident: id_next, y: py_q, x: px_q};
            slot_seen_d[sel_q]   = 1'b1;
            slot_valid_d[sel_q]  = 1'b1;
            id_cnt_d             = id_next;
          end else begin
            result_o.ev          = EV_TABLE_FULL;
          end
          state_d = S_IDLE;
        end
      end
      S_FE_CHK: begin
        if (slot_valid_q[sel_q] && !slot_seen_q[sel_q]) begin
          state_d = S_FE_EMIT;
        end else if (sel_q == '0) begin
          state_d = S_FE_END;
        end else begin
          sel_d = sel_q - IDX_W'(1);
        end
      end
      S_FE_EMIT: begin
        if (out_free_i) begin
          result_o.valid      = 1'b1;
          result_o.ev         = EV_LOST;
          result_o.ident      = mem_rdata_i.ident;
          result_o.x          = mem_rdata_i.x;
          result_o.y          = mem_rdata_i.y;
          slot_valid_d[sel_q] = 1'b0;
          if (sel_q == '0) begin
            state_d = S_FE_END;
          end else begin
            sel_d   = sel_q - IDX_W'(1);
            state_d = S_FE_CHK;
          end
        end
      end
      S_FE_END: begin
        if (out_free_i) begin
          result_o.valid = 1'b1;
          result_o.ev    = EV_FRAME_END;
          result_o.last  = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign issue_o = iss_q;
  assign det_x_o = px_q;
  assign det_y_o = py_q;

  a_hit_on_valid_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dist_res_i.valid && dist_res_i.hit) |-> slot_valid_q[dist_res_i.idx])
    else $error("distance hit reported for an empty slot");

  a_lost_is_unseen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FE_EMIT) |-> (slot_valid_q[sel_q] && !slot_seen_q[sel_q]))
    else $error("lost report for a slot that is empty or seen");

  a_seen_implies_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_seen_q & ~slot_valid_q) == '0)
    else $error("seen mark set on an empty slot");

  a_id_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (id_cnt_q != $past(id_cnt_q)) |-> ($past(state_q) == S_DET_EMIT))
    else $error("track identifier advanced outside a new-track report");

endmodule

// ----- rtl/core/centroid_track_associator_unit.sv -----
// Channel     Direction  Transaction contents
// s_axis      in         tuser: op; tdata: pos_x, pos_y
// m_axis      out        tuser: event_res; tdata: track_id, out_x, out_y; tlast: last
// cfg         in         tolerance write, no read-back
//
// Frame start: accepted while idle, then the report as soon as the output register is free.
// Detection: one slot read per cycle streams through the shared distance unit (3 stages),
// then a drain until the unit is empty, a table read of the chosen slot and the report; the
// input is ready again once the sequencer is back in idle.
// Frame end: a lost report per occupied, unseen slot, highest first, then the end marker.
// Reset clears all valid and seen marks at once; the table contents need no clearing.
// s_axis_tready is high only while idle; output stalls hold the sequencer in place.
module centroid_track_associator_unit
  import ctau_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Config: tolerance
  input  logic                   cfg_we_i,
  input  logic [TOL_W-1:0]       cfg_wdata_i,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [11:0] pos_x, [23:12] pos_y
  input  logic [OP_W-1:0]        s_axis_tuser,   // [1:0] op
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] track_id, [43:32] out_x,
                                                 // [55:44] out_y
  output logic [EV_W-1:0]        m_axis_tuser,   // [2:0] event_res
  output logic                   m_axis_tlast
);

  // Squared tolerance, kept ready for the distance compare.
  tol2_t tol2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol2_q <= TOL2_W'(TOL_RESET) * TOL2_W'(TOL_RESET);
    end else if (cfg_we_i) begin
      tol2_q <= TOL2_W'(cfg_wdata_i) * TOL2_W'(cfg_wdata_i);
    end
  end

  // Output register: a report waits here while the sequencer moves on.
  logic    out_valid_q;
  result_t out_q;
  result_t result;
  logic    out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (result.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result.valid) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_q.y, out_q.x, out_q.ident});
  assign m_axis_tuser  = out_q.ev;
  assign m_axis_tlast  = out_q.last;

  // Track table, sequencer and the shared distance unit.
  idx_t        mem_raddr, mem_waddr;
  track_word_t mem_rdata, mem_wdata;
  logic        mem_we;
  issue_t      issue;
  coord_t      det_x, det_y;
  dist_res_t   dist_res;
  logic        dist_busy;

  ctau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .pos_x_i     (s_axis_tdata[COORD_BITS-1:0]),
    .pos_y_i     (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .out_free_i  (out_free),
    .result_o    (result),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .issue_o     (issue),
    .det_x_o     (det_x),
    .det_y_o     (det_y),
    .dist_res_i  (dist_res),
    .dist_busy_i (dist_busy)
  );

  ctau_track_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Only occupied slots are sent into the compare.
  ctau_dist_unit u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (issue.valid && issue.slot_valid),
    .in_idx_i   (issue.idx),
    .trk_x_i    (mem_rdata.x),
    .trk_y_i    (mem_rdata.y),
    .det_x_i    (det_x),
    .det_y_i    (det_y),
    .tol2_i     (tol2_q),
    .res_o      (dist_res),
    .busy_o     (dist_busy)
  );

endmodule
